// ===== rtl/laps_pkg.sv =====
// Package for the load-average priority scheduler.
// Shared widths, constants, types and the controller state enum; no dependencies.
package laps_pkg;
	localparam int NUM_PROCS_DEF  = 16;
	localparam int WINDOW_LEN_DEF = 60;
	localparam int READY_MAX      = 64;
	localparam int RECENT_MAX     = 511;
	localparam int PRIO_MAX       = 2047;
	localparam int QUANT_MAX      = 1023;
	localparam logic [7:0] QUANTUM_RESET = 8'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_DIV,
		ST_READ,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_EMIT
	} laps_state_t;

	// controller -> datapath
	typedef struct packed {
		logic tick_start;   // update window from captured input
		logic load_start;   // start load division
		logic div_start;    // start per-entry division
		logic mul_en;       // register product and divisor
		logic rd_en;        // read table entry
		logic entry_done;   // result loaded for output, write back and advance
		logic out_load;     // load output register
	} laps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic last_entry;
	} laps_sts_t;
endpackage

// ===== rtl/laps_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Self-contained; no package dependencies.
module laps_divider #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted  = {rem_q, quo_q[W-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(W);
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/laps_datapath.sv =====
// Datapath: load window, process tables, shared divider and output register.
// Depends on laps_pkg and laps_divider.
module laps_datapath #(
	parameter int NUM_PROCS  = laps_pkg::NUM_PROCS_DEF,
	parameter int WINDOW_LEN = laps_pkg::WINDOW_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  laps_pkg::laps_cmd_t cmd,
	output laps_pkg::laps_sts_t sts,
	input  logic [6:0]          ready_count,
	input  logic                wr_en,
	input  logic [5:0]          wr_index,
	input  logic [7:0]          wr_base,
	input  logic [7:0]          wr_ext,
	input  logic [7:0]          quantum_base,
	input  logic                out_pop,
	output logic                out_valid,
	output logic [5:0]          entry_index,
	output logic [10:0]         priority_res,
	output logic [9:0]          quantum,
	output logic [8:0]          recent_usage,
	output logic [6:0]          load_average,
	output logic                last
);
	import laps_pkg::*;
	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int WW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int DW = 16;

	logic [6:0]  win_mem [WINDOW_LEN];
	logic [6:0]  win_rd_q;
	logic [WINDOW_LEN-1:0] win_vld_q;
	logic [WW-1:0] wptr_q;
	logic [11:0] sum_q;
	logic [6:0]  seen_q;
	logic [6:0]  ready_sat;
	logic [6:0]  old_sample;

	logic [NUM_PROCS-1:0] ent_vld_q;
	logic [8:0] recent_mem [NUM_PROCS];
	logic [7:0] base_mem [NUM_PROCS];
	logic [7:0] ext_mem [NUM_PROCS];
	logic [PW-1:0] idx_q;
	logic [8:0] rec_rd_q;
	logic [7:0] base_rd_q, ext_rd_q;
	logic [6:0] load_q;
	logic [15:0] prod_q, dvs_q;
	logic [DW-1:0] div_a, div_b, div_q;
	logic div_busy;
	logic [9:0] new_rec_w;
	logic [8:0] new_rec;
	logic [10:0] prio_sum;
	logic [9:0] quant_sum;

	assign ready_sat  = (ready_count > 7'(READY_MAX)) ? 7'(READY_MAX) : ready_count;
	// pointer is stable between ticks, so the registered read is current at the tick
	assign old_sample = win_vld_q[wptr_q] ? win_rd_q : 7'd0;

	always_ff @(posedge clk) begin
		if (cmd.tick_start) win_mem[wptr_q] <= ready_sat;
		win_rd_q <= win_mem[wptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			wptr_q    <= '0;
			sum_q     <= '0;
			seen_q    <= '0;
		end else if (cmd.tick_start) begin
			win_vld_q[wptr_q] <= 1'b1;
			sum_q  <= sum_q - 12'(old_sample) + 12'(ready_sat);
			if (seen_q < 7'(WINDOW_LEN)) seen_q <= seen_q + 1'b1;
			wptr_q <= (32'(wptr_q) + 1 >= WINDOW_LEN) ? '0 : wptr_q + 1'b1;
		end
	end

	// shared divider: load average, then one quotient per entry
	assign div_a = cmd.load_start ? DW'(sum_q) : prod_q;
	assign div_b = cmd.load_start ? DW'(seen_q) : dvs_q;

	laps_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.load_start | cmd.div_start),
		.dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
	);
	assign sts.div_busy   = div_busy;
	assign sts.last_entry = (32'(idx_q) == NUM_PROCS - 1);

	always_ff @(posedge clk) begin
		if (wr_en && 32'(wr_index) < NUM_PROCS) begin
			base_mem[wr_index[PW-1:0]] <= wr_base;
			ext_mem[wr_index[PW-1:0]]  <= wr_ext;
		end
		if (cmd.entry_done) recent_mem[idx_q] <= new_rec;
		if (cmd.rd_en) begin
			rec_rd_q  <= recent_mem[idx_q];
			base_rd_q <= base_mem[idx_q];
			ext_rd_q  <= ext_mem[idx_q];
		end
		if (cmd.mul_en) begin
			prod_q <= 16'(load_q) * 16'(ent_vld_q[idx_q] ? rec_rd_q : 9'd0);
			dvs_q  <= 16'({load_q, 1'b1});
		end
	end

	// write valid: bit 0 means never written since reset (base and ext read as zero)
	logic [NUM_PROCS-1:0] wr_vld_q;
	logic [7:0] base_eff, ext_eff;
	assign base_eff = wr_vld_q[idx_q] ? base_rd_q : 8'd0;
	assign ext_eff  = wr_vld_q[idx_q] ? ext_rd_q  : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			wr_vld_q  <= '0;
			idx_q     <= '0;
			load_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (wr_en && 32'(wr_index) < NUM_PROCS) wr_vld_q[wr_index[PW-1:0]] <= 1'b1;
			if (cmd.load_start) idx_q <= '0;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_pop) out_valid <= 1'b0;
			if (cmd.entry_done) begin
				ent_vld_q[idx_q] <= 1'b1;
				idx_q <= sts.last_entry ? '0 : idx_q + 1'b1;
			end
			if (cmd.rd_en && idx_q == '0) begin
				load_q <= (div_q > 16'(READY_MAX)) ? 7'(READY_MAX) : div_q[6:0];
			end
		end
	end

	assign new_rec_w = 10'(div_q[8:0]) + 10'(ext_eff);
	assign new_rec   = (div_q > 16'(RECENT_MAX) || new_rec_w > 10'(RECENT_MAX))
		? 9'(RECENT_MAX) : new_rec_w[8:0];
	assign prio_sum  = 11'(base_eff) + {2'b0, ext_eff, 1'b0} + 11'(new_rec);
	assign quant_sum = 10'(quantum_base) + 10'(new_rec);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			entry_index  <= 6'(idx_q);
			priority_res <= prio_sum;
			quantum      <= quant_sum;
			recent_usage <= new_rec;
			load_average <= load_q;
			last         <= sts.last_entry;
		end
	end
endmodule

// ===== rtl/laps_controller.sv =====
// Controller state machine sequencing tick, load division and entry walk.
// Depends on laps_pkg.
module laps_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_acc,
	input  logic                out_valid,
	input  logic                out_pop,
	input  laps_pkg::laps_sts_t sts,
	output laps_pkg::laps_cmd_t cmd,
	output logic                busy
);
	import laps_pkg::*;
	laps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (tick_acc) state_d = ST_LOAD_DIV;
			ST_LOAD_DIV: state_d = ST_READ;
			ST_READ:     if (!sts.div_busy) state_d = ST_MUL;
			ST_MUL:      state_d = ST_START;
			ST_START:    state_d = ST_DIV;
			ST_DIV:      if (!sts.div_busy && (!out_valid || out_pop)) state_d = ST_EMIT;
			ST_EMIT:     state_d = sts.last_entry ? ST_IDLE : ST_READ;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     cmd.tick_start = tick_acc;
			ST_LOAD_DIV: cmd.load_start = 1'b1;
			ST_READ:     cmd.rd_en = !sts.div_busy;
			ST_MUL:      cmd.mul_en = 1'b1;
			ST_START:    cmd.div_start = 1'b1;
			ST_EMIT: begin
				cmd.out_load   = 1'b1;
				cmd.entry_done = 1'b1;
			end
			default: cmd = '0;
		endcase
	end
endmodule

// ===== rtl/load_average_priority_scheduler.sv =====
// Top level of the load-average priority scheduler.
// Depends on laps_pkg, laps_controller and laps_datapath.
//
// Usage:
//   s_axis carries one transaction per item. s_axis_tuser is the opcode
//   (0 = tick, 1 = write entry). s_axis_tdata packs ready_count[6:0],
//   proc_index[12:7], base_prio[20:13], ext_prio[28:21].
//   A write updates one entry in the cycle it is accepted and emits nothing.
//   A tick pushes a sample into the window, divides the window sum by the
//   sample count, then walks all NUM_PROCS entries, emitting one m_axis
//   transaction per entry; m_axis_tlast marks the final entry.
//   The load division and each per-entry division use one shared 16-step
//   restoring divider. s_axis_tready drops during a tick walk; writes and
//   ticks wait. A stalled receiver holds the output register and pauses the
//   walk. Reset clears window, sum, count, pointer and every table entry
//   (through valid bits), and sets quantum_base to 2. quantum_base is written
//   through cfg_wr_en/cfg_wr_data; the user must write it only while idle,
//   as the block does not enforce this.
module load_average_priority_scheduler #(
	parameter int NUM_PROCS  = laps_pkg::NUM_PROCS_DEF,
	parameter int WINDOW_LEN = laps_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // ready_count, proc_index, base_prio, ext_prio
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // entry_index, priority_res, quantum, recent_usage,
	                                   // load_average
	output logic        m_axis_tlast,  // last
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import laps_pkg::*;
	laps_cmd_t cmd;
	laps_sts_t sts;
	logic busy, s_acc, out_pop;
	logic [7:0] quantum_base_q;
	logic [5:0] entry_index;
	logic [10:0] priority_res;
	logic [9:0] quantum;
	logic [8:0] recent_usage;
	logic [6:0] load_average;

	// accept only while idle so no tick overlaps a walk
	assign s_axis_tready = !busy;
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign out_pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        quantum_base_q <= QUANTUM_RESET;
		else if (cfg_wr_en) quantum_base_q <= cfg_wr_data;
	end

	laps_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.tick_acc(s_acc && s_axis_tuser == OP_TICK),
		.out_valid(m_axis_tvalid), .out_pop(out_pop),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	laps_datapath #(.NUM_PROCS(NUM_PROCS), .WINDOW_LEN(WINDOW_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.ready_count(s_axis_tdata[6:0]),
		.wr_en(s_acc && s_axis_tuser == OP_WRITE),
		.wr_index(s_axis_tdata[12:7]), .wr_base(s_axis_tdata[20:13]),
		.wr_ext(s_axis_tdata[28:21]), .quantum_base(quantum_base_q),
		.out_pop(out_pop), .out_valid(m_axis_tvalid),
		.entry_index(entry_index), .priority_res(priority_res), .quantum(quantum),
		.recent_usage(recent_usage), .load_average(load_average), .last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, load_average, recent_usage, quantum, priority_res,
		entry_index};
endmodule

// ===== rtl/laps_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
// Depends on load_average_priority_scheduler ports only.
module laps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// no input accepted while a result waits mid-walk
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready during walk");
	// saturation bound on the load average
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[42:36] <= 7'd64)
		else $error("load above range");
endmodule

bind load_average_priority_scheduler laps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// ===== dv/tb.sv =====
// Testbench for the load-average priority scheduler: directed and random
// ticks and entry writes, checked against an in-bench decay-usage predictor.
// Depends on laps_pkg and load_average_priority_scheduler.
module tb;
	import laps_pkg::*;

	localparam int NPROC = 16;
	localparam int WIN   = 60;

	typedef struct packed {
		logic [5:0]  entry;
		logic [10:0] prio;
		logic [9:0]  quant;
		logic [8:0]  recent;
		logic [6:0]  load;
		logic        last;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	load_average_priority_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  quantum_base = QUANTUM_RESET;
	logic [6:0]  load_hist[WIN];
	logic [11:0] hist_sum;
	int          hist_count, hist_ptr;
	logic [8:0]  recent_tbl[NPROC];
	logic [7:0]  base_tbl[NPROC];
	logic [7:0]  ext_tbl[NPROC];
	sched_result_t expected_results[$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int mismatches = 0;
	bit failed = 1'b0;

	// Advance the window and every entry's recent usage for one tick.
	task automatic predict_tick(input logic [6:0] ready_in);
		int ready, load, rec, prio, quant;
		sched_result_t r;
		ready = (ready_in > READY_MAX) ? READY_MAX : ready_in;
		hist_sum = 12'(hist_sum - load_hist[hist_ptr] + ready);
		load_hist[hist_ptr] = 7'(ready);
		if (hist_count < WIN) hist_count++;
		hist_ptr = (hist_ptr + 1 >= WIN) ? 0 : hist_ptr + 1;
		load = hist_sum / hist_count;
		if (load > READY_MAX) load = READY_MAX;
		for (int i = 0; i < NPROC; i++) begin
			rec = (load * recent_tbl[i]) / (2 * load + 1) + ext_tbl[i];
			if (rec > RECENT_MAX) rec = RECENT_MAX;
			recent_tbl[i] = 9'(rec);
			prio = base_tbl[i] + 2 * ext_tbl[i] + rec;
			if (prio > PRIO_MAX) prio = PRIO_MAX;
			quant = quantum_base + rec;
			if (quant > QUANT_MAX) quant = QUANT_MAX;
			r.entry = 6'(i); r.prio = 11'(prio); r.quant = 10'(quant);
			r.recent = 9'(rec); r.load = 7'(load); r.last = (i == NPROC - 1);
			expected_results.push_back(r);
		end
	endtask

	// Drive one transaction at the falling edge, hold until accepted.
	task automatic send_item(input logic op, input logic [6:0] ready,
			input logic [5:0] idx, input logic [7:0] bp, input logic [7:0] ep);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b0, ep, bp, idx, ready};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_WRITE) begin
			if (idx < NPROC) begin
				base_tbl[idx] = bp;
				ext_tbl[idx]  = ep;
			end
		end else
			predict_tick(ready);
		@(negedge clk);
	endtask

	task automatic send_tick(input logic [6:0] ready);
		send_item(OP_TICK, ready, 6'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic send_write(input logic [5:0] idx, input logic [7:0] bp,
			input logic [7:0] ep);
		send_item(OP_WRITE, 7'($urandom), idx, bp, ep);
	endtask

	// Drop valid, drain, then let a trailing write settle before touching the register.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_quantum(input logic [7:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		quantum_base = value;
	endtask

	// Receiver: random stalls, compare each transaction with the oldest expectation.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		sched_result_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[5:0], m_axis_tdata[16:6], m_axis_tdata[26:17],
				m_axis_tdata[35:27], m_axis_tdata[42:36], m_axis_tlast};
			if (expected_results.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected e%0d p%0d q%0d r%0d l%0d t%0d,",
							" got e%0d p%0d q%0d r%0d l%0d t%0d"},
							exp_r.entry, exp_r.prio, exp_r.quant, exp_r.recent,
							exp_r.load, exp_r.last, got.entry, got.prio, got.quant,
							got.recent, got.load, got.last);
				end
			end
		end
	end

	// Extremes: empty and full queues, over-range counts and indices, maximum priority values.
	task automatic test_directed();
		send_tick(7'd0);
		send_tick(7'd64);
		send_tick(7'd127);
		send_write(6'd0, 8'hFF, 8'hFF);
		send_write(6'd15, 8'h00, 8'hFF);
		send_write(6'd7, 8'hFF, 8'h00);
		send_write(6'd16, 8'h55, 8'hAA);
		send_write(6'd63, 8'hAA, 8'h55);
		send_tick(7'd65);
		send_tick(7'd1);
		write_quantum(8'd255);
		send_tick(7'd64);
		send_tick(7'd100);
		write_quantum(8'd0);
		send_tick(7'd0);
		send_write(6'd0, 8'h00, 8'h00);
		send_tick(7'd33);
	endtask

	// Random mix, mostly writes with ticks between; some writes beyond the table.
	task automatic test_random(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(2) == 0)
				send_tick(7'($urandom_range(3) == 0 ? $urandom : $urandom_range(64)));
			else
				send_write(6'($urandom_range(4) == 0 ? $urandom : $urandom_range(15)),
					8'($urandom), 8'($urandom_range(1) ? $urandom : $urandom_range(8)));
		end
	endtask

	// Slide past a full window so overwritten samples leave the sum.
	task automatic test_window_wrap();
		for (int k = 0; k < 70; k++) send_tick(7'($urandom_range(64)));
	endtask

	initial begin
		for (int i = 0; i < WIN; i++) load_hist[i] = '0;
		for (int i = 0; i < NPROC; i++) begin
			recent_tbl[i] = '0; base_tbl[i] = '0; ext_tbl[i] = '0;
		end
		hist_sum = '0; hist_count = 0; hist_ptr = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 31; sink_idle_pct = 83;
		test_directed();
		test_random(90);
		write_quantum(8'd17);
		src_idle_pct = 83; sink_idle_pct = 31;
		test_window_wrap();
		write_quantum(8'd128);
		src_idle_pct = 0; sink_idle_pct = 0;
		test_random(150);

		wait_idle();
		repeat (400) @(negedge clk);
		if (!failed && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Worst case: ~200 ticks x 16 results with heavy receiver stalls.
	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
